[sv/afm_pkg.sv]
// ----------------------------------------------------------------------------
// afm_pkg: shared types and constants of the NCO modulator
// Item and register types, the microcode format with its program, and the
// quarter-wave sine generator that is evaluated while the design elaborates.
// ----------------------------------------------------------------------------
package afm_pkg;

  // Fixed field widths of the channels and registers.
  localparam int unsigned MSG_BITS      = 16;
  localparam int unsigned OUT_BITS      = 18;
  localparam int unsigned CFG_IDX_BITS  = 4;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned STEP_BITS     = 32;
  localparam int unsigned AMP_BITS      = 15;
  localparam int unsigned FM_GAIN_BITS  = 31;
  localparam int unsigned PM_GAIN_BITS  = 32;

  // Signed operand of the shared multiplier that carries gains and factors.
  localparam int unsigned GAIN_OP_BITS  = 33;
  // Message values and amplitudes carry 15 fraction bits.
  localparam int unsigned GAIN_SHIFT    = 15;

  localparam logic signed [OUT_BITS-1:0] OUT_MAX = 18'sd131071;
  localparam logic signed [OUT_BITS-1:0] OUT_MIN = -18'sd131072;

  // Constants of the quarter-wave generator (Q30).
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    MODE_CARRIER = 3'd0,
    MODE_ASK     = 3'd1,
    MODE_FSK     = 3'd2,
    MODE_BPSK    = 3'd3,
    MODE_AM      = 3'd4,
    MODE_FM      = 3'd5,
    MODE_PM      = 3'd6
  } mode_e;

  // Register indexes of the configuration port.
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MODE          = 4'd0;
  localparam cfg_idx_t CFG_CARRIER_STEP  = 4'd1;
  localparam cfg_idx_t CFG_LOW_STEP      = 4'd2;
  localparam cfg_idx_t CFG_HIGH_STEP     = 4'd3;
  localparam cfg_idx_t CFG_LOW_AMPLITUDE = 4'd4;
  localparam cfg_idx_t CFG_AM_INDEX      = 4'd5;
  localparam cfg_idx_t CFG_FM_GAIN       = 4'd6;
  localparam cfg_idx_t CFG_PM_GAIN       = 4'd7;

  typedef struct packed {
    mode_e                    mode;
    logic [STEP_BITS-1:0]     carrier_step;
    logic [STEP_BITS-1:0]     low_step;
    logic [STEP_BITS-1:0]     high_step;
    logic [AMP_BITS-1:0]      low_amplitude;
    logic [AMP_BITS-1:0]      am_index;
    logic [FM_GAIN_BITS-1:0]  fm_gain;
    logic [PM_GAIN_BITS-1:0]  pm_gain;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    mode:          MODE_CARRIER,
    carrier_step:  32'd85899346,
    low_step:      32'd51539608,
    high_step:     32'd137438953,
    low_amplitude: 15'd9830,
    am_index:      15'd26214,
    fm_gain:       31'd42949673,
    pm_gain:       32'd820278192
  };

  // Channel payloads.
  typedef struct packed {
    logic signed [MSG_BITS-1:0] message_value;
    logic                       last_sample;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] output_sample;
  } out_item_t;

  // Microprogram addresses.
  typedef enum logic [2:0] {
    STEP_WAIT   = 3'd0,
    STEP_GAIN   = 3'd1,
    STEP_PHASE  = 3'd2,
    STEP_LOOKUP = 3'd3,
    STEP_SCALE  = 3'd4,
    STEP_EMIT   = 3'd5
  } step_e;

  typedef enum logic [1:0] {
    MUL_NONE  = 2'd0,
    MUL_GAIN  = 2'd1,
    MUL_SCALE = 2'd2
  } mul_sel_e;

  typedef enum logic {
    COND_NONE    = 1'b0,
    COND_NO_GAIN = 1'b1
  } cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic     take_in;
    mul_sel_e mul_sel;
    logic     phase_ld;
    logic     rom_ld;
    logic     emit;
    cond_e    cond;
    step_e    jump_to;
    step_e    next_step;
  } uword_t;

  // Controls from the sequencer to the datapath, handshakes already qualified.
  typedef struct packed {
    logic     in_ready;
    logic     accept;
    mul_sel_e mul_sel;
    logic     phase_ld;
    logic     rom_ld;
    logic     emit;
  } ctrl_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic out_busy;
    logic needs_gain;
  } status_t;

  // Microprogram ROM. A step that waits on a handshake holds until it completes.
  function automatic uword_t afm_ucode(input step_e step);
    uword_t w;
    w = '0;
    unique case (step)
      STEP_WAIT: begin
        w.take_in   = 1'b1;
        w.cond      = COND_NO_GAIN;
        w.jump_to   = STEP_PHASE;
        w.next_step = STEP_GAIN;
      end
      STEP_GAIN: begin
        w.mul_sel   = MUL_GAIN;
        w.next_step = STEP_PHASE;
      end
      STEP_PHASE: begin
        w.phase_ld  = 1'b1;
        w.next_step = STEP_LOOKUP;
      end
      STEP_LOOKUP: begin
        w.rom_ld    = 1'b1;
        w.next_step = STEP_SCALE;
      end
      STEP_SCALE: begin
        w.mul_sel   = MUL_SCALE;
        w.next_step = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit      = 1'b1;
        w.next_step = STEP_WAIT;
      end
      default: begin
        w.next_step = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  // Unsigned quotient by shift and subtract. Used at elaboration only.
  function automatic longint unsigned afm_udiv(
    input longint unsigned num,
    input longint unsigned den
  );
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Magnitude of sin(j/2^qtr_bits * pi/2), scaled to full_scale. Q30 Horner
  // series up to x^15, rounded and clamped. Used at elaboration only.
  function automatic longint unsigned afm_quarter_value(
    input longint unsigned j,
    input int unsigned     qtr_bits,
    input longint unsigned full_scale
  );
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned d;
    longint unsigned v;
    x  = (j * HALF_PI_Q30) >> qtr_bits;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    for (int n = 7; n >= 1; n--) begin
      d = 64'(2 * n) * 64'(2 * n + 1);
      t = ONE_Q30 - afm_udiv((x2 * t) >> 30, d);
    end
    s = (x * t) >> 30;
    v = (s * full_scale + (ONE_Q30 >> 1)) >> 30;
    return (v > full_scale) ? full_scale : v;
  endfunction

endpackage

[sv/afm_if.sv]
// ----------------------------------------------------------------------------
// afm_if: channel interfaces of the NCO modulator
// A valid/ready stream with a typed payload, and the register write channel.
// ----------------------------------------------------------------------------

// Stream channel: one beat moves when valid and ready are both high.
interface afm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// Register write channel: one write per beat.
interface afm_cfg_if import afm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  cfg_idx_t                 index;
  logic [CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/afm_cfg_regs.sv]
// ----------------------------------------------------------------------------
// afm_cfg_regs: configuration register file
// Holds mode, phase steps, amplitudes and gains; writes to unknown indexes
// are dropped.
// ----------------------------------------------------------------------------
module afm_cfg_regs import afm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  afm_cfg_if.sink   cfg_i,
  output cfg_t      cfg_o
);

  cfg_t cfg_q;

  // The register file takes a write in every cycle.
  assign cfg_i.ready = 1'b1;

  // Register writes, each value truncated to its register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.index)
        CFG_MODE:          cfg_q.mode          <= mode_e'(cfg_i.data[2:0]);
        CFG_CARRIER_STEP:  cfg_q.carrier_step  <= cfg_i.data[STEP_BITS-1:0];
        CFG_LOW_STEP:      cfg_q.low_step      <= cfg_i.data[STEP_BITS-1:0];
        CFG_HIGH_STEP:     cfg_q.high_step     <= cfg_i.data[STEP_BITS-1:0];
        CFG_LOW_AMPLITUDE: cfg_q.low_amplitude <= cfg_i.data[AMP_BITS-1:0];
        CFG_AM_INDEX:      cfg_q.am_index      <= cfg_i.data[AMP_BITS-1:0];
        CFG_FM_GAIN:       cfg_q.fm_gain       <= cfg_i.data[FM_GAIN_BITS-1:0];
        CFG_PM_GAIN:       cfg_q.pm_gain       <= cfg_i.data[PM_GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

[sv/afm_sequencer.sv]
// ----------------------------------------------------------------------------
// afm_sequencer: microprogram counter and control word fetch
// Steps through the control program, holds on open handshakes and takes the
// conditional jump that skips the message gain pass.
// ----------------------------------------------------------------------------
module afm_sequencer import afm_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  status_t status_i,
  output ctrl_t   ctrl_o
);

  step_e  step_q;
  step_e  step_d;
  uword_t uword;
  logic   stall;
  logic   take_jump;

  // Fetch the control word of the current step.
  assign uword = afm_ucode(step_q);

  // Hold on an input step without a beat, or an output step with a full register.
  assign stall = (uword.take_in && !in_valid_i) || (uword.emit && status_i.out_busy);

  // Jump condition.
  always_comb begin
    unique case (uword.cond)
      COND_NONE:    take_jump = 1'b0;
      COND_NO_GAIN: take_jump = !status_i.needs_gain;
    endcase
  end

  // Next program address.
  always_comb begin
    if (stall) begin
      step_d = step_q;
    end else if (take_jump) begin
      step_d = uword.jump_to;
    end else begin
      step_d = uword.next_step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_WAIT;
    end else begin
      step_q <= step_d;
    end
  end

  // Control outputs, handshake strobes qualified by the stall.
  always_comb begin
    ctrl_o.in_ready = uword.take_in;
    ctrl_o.accept   = uword.take_in && in_valid_i;
    ctrl_o.mul_sel  = uword.mul_sel;
    ctrl_o.phase_ld = uword.phase_ld;
    ctrl_o.rom_ld   = uword.rom_ld;
    ctrl_o.emit     = uword.emit && !status_i.out_busy;
  end

endmodule

[sv/afm_sine_rom.sv]
// ----------------------------------------------------------------------------
// afm_sine_rom: full-wave sine lookup from a quarter-wave table
// The quarter table is built at elaboration; quadrant folding and sign are
// applied on the read, and the sample is registered.
// ----------------------------------------------------------------------------
module afm_sine_rom import afm_pkg::*; #(
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS    = 16
) (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [SINE_ADDR_BITS-1:0]     addr_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam int unsigned QTR_BITS = SINE_ADDR_BITS - 2;
  localparam int unsigned QTR_SIZE = 1 << QTR_BITS;
  localparam int unsigned MAG_BITS = SAMPLE_BITS - 1;
  localparam longint unsigned FULL_SCALE = (64'd1 << MAG_BITS) - 64'd1;

  // Quarter table with both end points, entries 0 through QTR_SIZE.
  typedef logic [(QTR_SIZE+1)*MAG_BITS-1:0] qtab_t;

  function automatic qtab_t build_qtab();
    qtab_t tab;
    tab = '0;
    for (int unsigned k = 0; k <= QTR_SIZE; k++) begin
      tab[k*MAG_BITS +: MAG_BITS] =
        MAG_BITS'(afm_quarter_value(64'(k), QTR_BITS, FULL_SCALE));
    end
    return tab;
  endfunction

  localparam qtab_t QTAB = build_qtab();

  logic [1:0]             quad;
  logic [QTR_BITS-1:0]    ofs;
  logic [QTR_BITS:0]      idx;
  logic [MAG_BITS-1:0]    mag;
  logic [SAMPLE_BITS-1:0] mag_ext;
  logic signed [SAMPLE_BITS-1:0] sample_q;

  // Quadrants one and three read the table backward; the upper half is negative.
  assign quad    = addr_i[SINE_ADDR_BITS-1 -: 2];
  assign ofs     = addr_i[QTR_BITS-1:0];
  assign idx     = quad[0] ? ((QTR_BITS+1)'(QTR_SIZE) - {1'b0, ofs}) : {1'b0, ofs};
  assign mag     = QTAB[idx*MAG_BITS +: MAG_BITS];
  assign mag_ext = {1'b0, mag};

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      sample_q <= quad[1] ? -mag_ext : mag_ext;
    end
  end

  assign sample_o = sample_q;

endmodule

[sv/afm_datapath.sv]
// ----------------------------------------------------------------------------
// afm_datapath: phase accumulators, shared multiplier and output stage
// Runs under the sequencer's control word: message gain product, phase
// selection, sine lookup, amplitude product, rounding and saturation.
// ----------------------------------------------------------------------------
module afm_datapath import afm_pkg::*; #(
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  ctrl_t     ctrl_i,
  input  in_item_t  in_item_i,
  input  logic      out_ready_i,
  output status_t   status_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  localparam int unsigned FRAC_BITS  = SAMPLE_BITS - 1;
  localparam int unsigned MUL_B_BITS = (SAMPLE_BITS > MSG_BITS) ? SAMPLE_BITS : MSG_BITS;
  localparam int unsigned PROD_BITS  = GAIN_OP_BITS + MUL_B_BITS;
  localparam int unsigned SUM_BITS   = PROD_BITS + 1;
  // Plain modes scale by 2^15, so both cases shift a product down to Q15.
  localparam int unsigned SH_PLAIN   = FRAC_BITS;
  localparam int unsigned SH_AM      = FRAC_BITS + GAIN_SHIFT;

  localparam logic signed [SUM_BITS-1:0] RND_PLAIN = SUM_BITS'(1) << (SH_PLAIN - 1);
  localparam logic signed [SUM_BITS-1:0] RND_AM    = SUM_BITS'(1) << (SH_AM - 1);
  localparam logic signed [GAIN_OP_BITS-1:0] FACTOR_UNITY = 33'sd32768;
  localparam logic signed [GAIN_OP_BITS-1:0] AM_ONE       = 33'sh0_4000_0000;
  localparam logic [PHASE_BITS-1:0] HALF_TURN    = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [PHASE_BITS-1:0] QUARTER_TURN = {2'b01, {(PHASE_BITS-2){1'b0}}};

  // Captured input beat.
  logic signed [MSG_BITS-1:0] msg_q;
  logic                       last_q;
  logic                       msg_bit;

  // Phase accumulators and the selected lookup phase.
  logic [PHASE_BITS-1:0] carrier_phase_q;
  logic [PHASE_BITS-1:0] low_phase_q;
  logic [PHASE_BITS-1:0] high_phase_q;
  logic [PHASE_BITS-1:0] fm_phase_q;
  logic [PHASE_BITS-1:0] phase_q;
  logic [PHASE_BITS-1:0] phase_d;
  logic [PHASE_BITS-1:0] carrier_step;
  logic [PHASE_BITS-1:0] offset_ext;
  logic [PHASE_BITS-1:0] fm_sum;
  logic signed [GAIN_OP_BITS-1:0] offset;

  // Shared multiplier.
  logic signed [GAIN_OP_BITS-1:0] mul_a;
  logic signed [MUL_B_BITS-1:0]   mul_b;
  logic signed [PROD_BITS-1:0]    prod_d;
  logic signed [PROD_BITS-1:0]    prod_q;
  logic signed [GAIN_OP_BITS-1:0] factor_q;
  logic signed [GAIN_OP_BITS-1:0] factor_d;
  logic signed [SAMPLE_BITS-1:0]  rom_sample;
  logic signed [SAMPLE_BITS-1:0]  rom_sample_w;

  // Output stage.
  logic signed [SUM_BITS-1:0] round_sum;
  logic signed [SUM_BITS-1:0] y_wide;
  logic signed [OUT_BITS-1:0] y_sat;
  logic                       out_valid_q;
  out_item_t                  out_item_q;

  // Mode decode.
  logic is_am;
  logic needs_gain;
  logic mode_known;

  always_comb begin
    is_am      = 1'b0;
    needs_gain = 1'b0;
    mode_known = 1'b1;
    unique case (cfg_i.mode)
      MODE_AM: begin
        is_am      = 1'b1;
        needs_gain = 1'b1;
      end
      MODE_FM, MODE_PM: begin
        needs_gain = 1'b1;
      end
      MODE_CARRIER, MODE_ASK, MODE_FSK, MODE_BPSK: begin
      end
      default: begin
        mode_known = 1'b0;
      end
    endcase
  end

  // Input capture.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      msg_q  <= in_item_i.message_value;
      last_q <= in_item_i.last_sample;
    end
  end

  assign msg_bit = (msg_q != '0);

  // Multiplier operands: gain times message, or factor times sine sample.
  assign rom_sample = rom_sample_w;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.mul_sel)
      MUL_GAIN: begin
        mul_b = MUL_B_BITS'(msg_q);
        if (is_am) begin
          mul_a = GAIN_OP_BITS'(cfg_i.am_index);
        end else if (cfg_i.mode == MODE_FM) begin
          mul_a = GAIN_OP_BITS'(cfg_i.fm_gain);
        end else begin
          mul_a = GAIN_OP_BITS'(cfg_i.pm_gain);
        end
      end
      MUL_SCALE: begin
        mul_a = factor_q;
        mul_b = MUL_B_BITS'(rom_sample);
      end
      default: begin
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_sel != MUL_NONE) begin
      prod_q <= prod_d;
    end
  end

  // Phase offset: gain product floored to whole phase units, wrapped to the phase width.
  assign offset       = prod_q[GAIN_SHIFT +: GAIN_OP_BITS];
  assign offset_ext   = PHASE_BITS'(offset);
  assign carrier_step = PHASE_BITS'(cfg_i.carrier_step);
  assign fm_sum       = fm_phase_q + carrier_step + offset_ext;

  // Lookup phase per mode.
  always_comb begin
    unique case (cfg_i.mode)
      MODE_FSK:  phase_d = msg_bit ? high_phase_q : low_phase_q;
      MODE_BPSK: phase_d = msg_bit ? (carrier_phase_q + HALF_TURN) : carrier_phase_q;
      MODE_AM:   phase_d = carrier_phase_q + QUARTER_TURN;
      MODE_FM:   phase_d = fm_sum;
      MODE_PM:   phase_d = carrier_phase_q + offset_ext;
      default:   phase_d = carrier_phase_q;
    endcase
  end

  // Amplitude factor for the second product.
  always_comb begin
    if (is_am) begin
      factor_d = AM_ONE + signed'(prod_q[GAIN_OP_BITS-1:0]);
    end else if ((cfg_i.mode == MODE_ASK) && !msg_bit) begin
      factor_d = GAIN_OP_BITS'(cfg_i.low_amplitude);
    end else begin
      factor_d = FACTOR_UNITY;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.phase_ld) begin
      phase_q  <= phase_d;
      factor_q <= factor_d;
    end
  end

  // Sine lookup.
  afm_sine_rom #(
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_sine_rom (
    .clk_i    (clk_i),
    .rd_en_i  (ctrl_i.rom_ld),
    .addr_i   (phase_q[PHASE_BITS-1 -: SINE_ADDR_BITS]),
    .sample_o (rom_sample_w)
  );

  // Accumulators advance once per sample; a last beat clears all of them.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carrier_phase_q <= '0;
      low_phase_q     <= '0;
      high_phase_q    <= '0;
      fm_phase_q      <= '0;
    end else if (ctrl_i.emit) begin
      if (last_q) begin
        carrier_phase_q <= '0;
        low_phase_q     <= '0;
        high_phase_q    <= '0;
        fm_phase_q      <= '0;
      end else begin
        carrier_phase_q <= carrier_phase_q + carrier_step;
        low_phase_q     <= low_phase_q + PHASE_BITS'(cfg_i.low_step);
        high_phase_q    <= high_phase_q + PHASE_BITS'(cfg_i.high_step);
      end
    end else if (ctrl_i.phase_ld && (cfg_i.mode == MODE_FM)) begin
      fm_phase_q <= fm_sum;
    end
  end

  // Round half up to Q15, then saturate to the output range; an unknown mode gives zero.
  assign round_sum = SUM_BITS'(prod_q) + (is_am ? RND_AM : RND_PLAIN);
  assign y_wide    = is_am ? (round_sum >>> SH_AM) : (round_sum >>> SH_PLAIN);

  always_comb begin
    if (!mode_known) begin
      y_sat = '0;
    end else if (y_wide > OUT_MAX) begin
      y_sat = OUT_MAX;
    end else if (y_wide < OUT_MIN) begin
      y_sat = OUT_MIN;
    end else begin
      y_sat = y_wide[OUT_BITS-1:0];
    end
  end

  // Output register: holds a beat until the sink takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_item_q.output_sample <= y_sat;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_item_o          = out_item_q;
  assign status_o.out_busy   = out_valid_q && !out_ready_i;
  assign status_o.needs_gain = needs_gain;

endmodule

[sv/ask_fsk_psk_am_fm_pm_modulator_unit.sv]
// ----------------------------------------------------------------------------
// ask_fsk_psk_am_fm_pm_modulator_unit: NCO based digital and analog modulator
// One modulated Q2.15 sample per message beat in carrier, ASK, FSK, BPSK,
// AM, FM or PM mode, from phase accumulators and a quarter-wave sine table.
// ----------------------------------------------------------------------------
// Each message beat yields exactly one output beat. The block works on one
// beat at a time under a six-step microprogram: carrier, ASK, FSK and BPSK
// skip the gain step, while AM, FM and PM make an extra pass through the
// single shared 33-bit multiplier to form the message gain product. The
// other steps are phase selection, the registered sine table read, the
// amplitude product and the rounding and saturation into the output
// register. The next beat is accepted in the cycle after a result is
// registered; a result waits there while the sink is not ready, and the
// block stalls only if a second result is done before the first was taken.
// Registers may be written whenever no beat is in flight. A last beat clears
// all phase accumulators after its sample. There is no clearing pass after
// reset.
module ask_fsk_psk_am_fm_pm_modulator_unit import afm_pkg::*; #(
  parameter int unsigned PHASE_BITS     = 32,
  parameter int unsigned SINE_ADDR_BITS = 10,
  parameter int unsigned SAMPLE_BITS    = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  afm_cfg_if.sink       cfg_i,
  afm_stream_if.sink    msg_i,
  afm_stream_if.source  smp_o
);

  cfg_t      cfg;
  ctrl_t     ctrl;
  status_t   status;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  // Configuration registers.
  afm_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Microprogram sequencer.
  afm_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (msg_i.valid),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // Datapath with the sine table.
  assign in_item = msg_i.payload;

  afm_datapath #(
    .PHASE_BITS     (PHASE_BITS),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .SAMPLE_BITS    (SAMPLE_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .in_item_i   (in_item),
    .out_ready_i (smp_o.ready),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_item_o  (out_item)
  );

  // Channel handshakes.
  assign msg_i.ready   = ctrl.in_ready;
  assign smp_o.valid   = out_valid;
  assign smp_o.payload = out_item;

endmodule
